[hdl/qpc_pkg.sv]
// Shared types, constants and character decoding for the Q-gram composition classifier.
// No dependencies; every other file except qpc_ram refers to this package by scoped names.
package qpc_pkg;

  // Field widths
  localparam int CHAR_W     = 8;
  localparam int GRAM_W     = 64;
  localparam int CNT_W      = 6;
  localparam int ID_W       = 13;

  // Defaults for the top-level parameters
  localparam int GRAM_LEN_DEF    = 32;
  localparam int MAX_CLASSES_DEF = 6545;

  // Class table: indexed by {count_a, count_c, count_g}, entry = {valid, id}
  localparam int TABLE_AW    = 3 * CNT_W;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;
  localparam int ENTRY_W     = ID_W + 1;

  // Result queue depth (covers one lookup in flight plus a stalled receiver)
  localparam int OUTQ_DEPTH = 3;

  // Characters of interest
  localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_GT   = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_SEMI = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC   = 8'h43;
  localparam logic [CHAR_W-1:0] CH_UG   = 8'h47;
  localparam logic [CHAR_W-1:0] CH_UT   = 8'h54;
  localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC   = 8'h63;
  localparam logic [CHAR_W-1:0] CH_LG   = 8'h67;
  localparam logic [CHAR_W-1:0] CH_LT   = 8'h74;

  // 2-bit base codes
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  typedef enum logic [1:0] {
    KIND_BASE,
    KIND_NEWLINE,
    KIND_HEADER,
    KIND_OTHER
  } char_kind_t;

  // Lookup request from the window stage to the class stage
  typedef struct packed {
    logic              valid;
    logic [GRAM_W-1:0] gram;
    logic [CNT_W-1:0]  count_a;
    logic [CNT_W-1:0]  count_c;
    logic [CNT_W-1:0]  count_g;
    logic [CNT_W-1:0]  count_t;
  } lookup_req_t;

  // One result item
  typedef struct packed {
    logic [GRAM_W-1:0] gram;
    logic [CNT_W-1:0]  count_a;
    logic [CNT_W-1:0]  count_c;
    logic [CNT_W-1:0]  count_g;
    logic [CNT_W-1:0]  count_t;
    logic [ID_W-1:0]   class_id;
    logic              new_class;
  } result_t;

  function automatic char_kind_t char_kind(input logic [CHAR_W-1:0] c);
    char_kind_t k;
    unique case (c) inside
      CH_NL:                         k = KIND_NEWLINE;
      CH_GT, CH_SEMI:                k = KIND_HEADER;
      CH_UA, CH_UC, CH_UG, CH_UT,
      CH_LA, CH_LC, CH_LG, CH_LT:    k = KIND_BASE;
      default:                       k = KIND_OTHER;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] c);
    logic [1:0] b;
    unique case (c) inside
      CH_UC, CH_LC: b = BASE_C;
      CH_UG, CH_LG: b = BASE_G;
      CH_UT, CH_LT: b = BASE_T;
      default:      b = BASE_A;
    endcase
    return b;
  endfunction

endpackage

[hdl/fasta_qgram_parikh_classifier.sv]
// Top level of the FASTA Q-gram composition classifier.
// Uses qpc_pkg, qpc_window, qpc_classify (with qpc_ram) and qpc_outq.
//
// Usage:
//   Input channel (in_valid/in_ready/in_char_in) takes one byte of FASTA text per
//   request. Bases A, C, G, T in either case enter a window of GRAM_LEN bases; a
//   newline is skipped; '>' or ';' opens a header that runs to the next newline;
//   any other byte restarts the window.
//   Result channel (out_valid/out_ready/out_*) carries one request per base that
//   completes a full window: the packed gram, its four base counts, the dense
//   class id of the count vector and a flag set when that vector takes a new id.
// Throughput: one byte per cycle unless in_ready stalls it. The class table is a single
//   read-modify-write memory; the lookup result of one byte is forwarded to the
//   next, so back-to-back bases with equal composition need no bubble.
// Result path: the table is read at the edge that accepts a byte, and the result
//   enters the queue at the next edge, from which it is offered.
// Reset: rst_n clears the window, counts, header flag and class counter, then a
//   clearing pass walks all 262144 entries of the class table, one entry a cycle;
//   in_ready stays low until it finishes.
// Stall: a three-entry result queue absorbs the lookup in flight; in_ready drops
//   during the clearing pass and when the queue and the lookup stage hold three results.
module fasta_qgram_parikh_classifier #(
  parameter int GRAM_LEN    = qpc_pkg::GRAM_LEN_DEF,
  parameter int MAX_CLASSES = qpc_pkg::MAX_CLASSES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [qpc_pkg::CHAR_W-1:0] in_char_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [qpc_pkg::GRAM_W-1:0] out_gram,
  output logic [qpc_pkg::CNT_W-1:0]  out_count_a,
  output logic [qpc_pkg::CNT_W-1:0]  out_count_c,
  output logic [qpc_pkg::CNT_W-1:0]  out_count_g,
  output logic [qpc_pkg::CNT_W-1:0]  out_count_t,
  output logic [qpc_pkg::ID_W-1:0]   out_class_id,
  output logic                       out_new_class
);

  localparam int QCW = $clog2(qpc_pkg::OUTQ_DEPTH + 1);

  qpc_pkg::lookup_req_t req;
  qpc_pkg::result_t     res, q_data;
  logic                 accept, busy, res_valid;
  logic [QCW-1:0]       q_level;
  logic [QCW:0]         occupancy;

  // Hold new bytes while the queue plus the lookup in flight could not take a result
  assign occupancy = (QCW + 1)'(q_level) + (QCW + 1)'(res_valid);
  assign in_ready  = !busy && (occupancy < (QCW + 1)'(qpc_pkg::OUTQ_DEPTH));
  assign accept    = in_valid && in_ready;

  qpc_window #(
    .GRAM_LEN(GRAM_LEN)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .char_in(in_char_in),
    .req    (req)
  );

  qpc_classify #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .busy     (busy),
    .res_valid(res_valid),
    .res      (res)
  );

  qpc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .pop_ready(out_ready),
    .pop_valid(out_valid),
    .pop_data (q_data),
    .level    (q_level)
  );

  assign out_gram      = q_data.gram;
  assign out_count_a   = q_data.count_a;
  assign out_count_c   = q_data.count_c;
  assign out_count_g   = q_data.count_g;
  assign out_count_t   = q_data.count_t;
  assign out_class_id  = q_data.class_id;
  assign out_new_class = q_data.new_class;

`ifndef ASSERT_OFF
  a_counts_sum_to_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (8'(out_count_a) + 8'(out_count_c) + 8'(out_count_g)
                   + 8'(out_count_t)) == 8'(GRAM_LEN))
    else $error("base counts do not cover the whole gram");
`endif

endmodule

[hdl/qpc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module qpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/qpc_window.sv]
// Window stage: FASTA byte parsing, 2-bit base window, per-base counts.
// Uses qpc_pkg; issues a lookup request for every full Q-gram.
module qpc_window #(
  parameter int GRAM_LEN = qpc_pkg::GRAM_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [qpc_pkg::CHAR_W-1:0] char_in,
  output qpc_pkg::lookup_req_t       req
);

  localparam int WIN_W  = 2 * GRAM_LEN;
  localparam int FILL_W = $clog2(GRAM_LEN + 1);
  localparam int CW     = qpc_pkg::CNT_W;

  logic [WIN_W-1:0]  window_r, window_nxt, window_shift;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_upd;
  logic [CW-1:0]     cnt_r [4];
  logic [CW-1:0]     cnt_nxt [4];
  logic [CW-1:0]     cnt_upd [4];
  logic              in_header_r, in_header_nxt;
  logic              full;
  logic [1:0]        code, old;
  qpc_pkg::char_kind_t kind;

  assign kind         = qpc_pkg::char_kind(char_in);
  assign code         = qpc_pkg::base_code(char_in);
  assign full         = (fill_r == FILL_W'(GRAM_LEN));
  assign old          = window_r[WIN_W-1 -: 2];
  assign window_shift = WIN_W'({window_r, code});
  assign fill_upd     = full ? fill_r : fill_r + FILL_W'(1);

  // Enter the new base, retire the oldest once the window is full
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      cnt_upd[b] = cnt_r[b] + CW'(code == 2'(b)) - CW'(full && (old == 2'(b)));
    end
  end

  always_comb begin
    window_nxt    = window_r;
    fill_nxt      = fill_r;
    in_header_nxt = in_header_r;
    for (int b = 0; b < 4; b++) begin
      cnt_nxt[b] = cnt_r[b];
    end
    req.valid   = 1'b0;
    req.gram    = qpc_pkg::GRAM_W'(window_shift);
    req.count_a = cnt_upd[0];
    req.count_c = cnt_upd[1];
    req.count_g = cnt_upd[2];
    req.count_t = cnt_upd[3];

    if (accept) begin
      if (in_header_r) begin
        if (kind == qpc_pkg::KIND_NEWLINE) begin
          in_header_nxt = 1'b0;
        end
      end else begin
        unique case (kind)
          qpc_pkg::KIND_NEWLINE: begin
            // keep the window across line breaks
            in_header_nxt = 1'b0;
          end
          qpc_pkg::KIND_HEADER: begin
            window_nxt    = '0;
            fill_nxt      = '0;
            in_header_nxt = 1'b1;
            for (int b = 0; b < 4; b++) cnt_nxt[b] = '0;
          end
          qpc_pkg::KIND_BASE: begin
            window_nxt = window_shift;
            fill_nxt   = fill_upd;
            for (int b = 0; b < 4; b++) cnt_nxt[b] = cnt_upd[b];
            req.valid  = (fill_upd == FILL_W'(GRAM_LEN));
          end
          default: begin
            window_nxt = '0;
            fill_nxt   = '0;
            for (int b = 0; b < 4; b++) cnt_nxt[b] = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= '0;
      fill_r      <= '0;
      in_header_r <= 1'b0;
      for (int b = 0; b < 4; b++) cnt_r[b] <= '0;
    end else begin
      window_r    <= window_nxt;
      fill_r      <= fill_nxt;
      in_header_r <= in_header_nxt;
      for (int b = 0; b < 4; b++) cnt_r[b] <= cnt_nxt[b];
    end
  end

endmodule

[hdl/qpc_classify.sv]
// Class stage: read-modify-write of the composition class table, with forwarding.
// Uses qpc_pkg and qpc_ram; runs the table clearing pass after reset.
module qpc_classify #(
  parameter int MAX_CLASSES = qpc_pkg::MAX_CLASSES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qpc_pkg::lookup_req_t req,
  output logic                 busy,
  output logic                 res_valid,
  output qpc_pkg::result_t     res
);

  localparam int AW = qpc_pkg::TABLE_AW;
  localparam int EW = qpc_pkg::ENTRY_W;
  localparam int IW = qpc_pkg::ID_W;

  logic                 clr_busy_r;
  logic [AW-1:0]        clr_addr_r;
  logic                 s1_valid_r;
  qpc_pkg::lookup_req_t s1_req_r;
  logic [AW-1:0]        s1_idx_r;
  logic [IW-1:0]        next_class_r, next_class_nxt;
  logic                 fwd_hit_r;
  logic [EW-1:0]        fwd_data_r;

  logic [AW-1:0] rd_idx;
  logic [EW-1:0] ram_rdata, entry;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          hit, alloc;

  assign rd_idx = {req.count_a, req.count_c, req.count_g};

  qpc_ram #(
    .WIDTH(EW),
    .DEPTH(qpc_pkg::TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_idx),
    .rd_data(ram_rdata)
  );

  // Entry seen by the stage: forwarded write if the item ahead wrote the same index
  assign entry = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign hit   = entry[EW-1];
  assign alloc = s1_valid_r && !hit && (next_class_r < IW'(MAX_CLASSES));

  always_comb begin
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = alloc;
      wr_addr = s1_idx_r;
      wr_data = {1'b1, next_class_r};
    end
  end

  assign next_class_nxt = alloc ? next_class_r + IW'(1) : next_class_r;

  always_comb begin
    res.gram      = s1_req_r.gram;
    res.count_a   = s1_req_r.count_a;
    res.count_c   = s1_req_r.count_c;
    res.count_g   = s1_req_r.count_g;
    res.count_t   = s1_req_r.count_t;
    res.new_class = alloc;
    if (hit) begin
      res.class_id = entry[IW-1:0];
    end else if (alloc) begin
      res.class_id = next_class_r;
    end else begin
      res.class_id = IW'(MAX_CLASSES - 1);
    end
  end

  assign res_valid = s1_valid_r;
  assign busy      = clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r   <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      next_class_r <= '0;
      fwd_hit_r    <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (&clr_addr_r) clr_busy_r <= 1'b0;
      end
      s1_valid_r   <= req.valid;
      next_class_r <= next_class_nxt;
      fwd_hit_r    <= req.valid && wr_en && (wr_addr == rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r   <= req;
    s1_idx_r   <= rd_idx;
    fwd_data_r <= wr_data;
  end

`ifndef ASSERT_OFF
  a_no_lookup_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s1_valid_r && !req.valid)
    else $error("class lookup during table clearing pass");

  a_alloc_advances_id: assert property (@(posedge clk) disable iff (!rst_n)
    alloc |=> next_class_r == $past(next_class_r) + IW'(1))
    else $error("class counter did not advance on allocation");

  a_id_below_counter: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && hit |-> entry[IW-1:0] < next_class_r)
    else $error("table returned an unassigned class id");
`endif

endmodule

[hdl/qpc_outq.sv]
// Result queue: small circular buffer that decouples the class stage from the receiver.
// Uses qpc_pkg for the result type and depth.
module qpc_outq (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  input  qpc_pkg::result_t                       push_data,
  input  logic                                   pop_ready,
  output logic                                   pop_valid,
  output qpc_pkg::result_t                       pop_data,
  output logic [$clog2(qpc_pkg::OUTQ_DEPTH+1)-1:0] level
);

  localparam int DEPTH = qpc_pkg::OUTQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  qpc_pkg::result_t q_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             pop;

  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = q_r[rd_ptr_r];
  assign level     = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    if (!push && pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_data;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < CW'(DEPTH)) || pop)
    else $error("result queue overflow");
`endif

endmodule
